// ----- sv/fbpa_pkg.sv -----
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int unsigned CW = 9;
    localparam int unsigned BW = 17;

    localparam logic [0:0] CFG_NUM_BLOCKS  = 1'b0;
    localparam logic [0:0] CFG_BLOCK_BYTES = 1'b1;

    localparam logic [CW-1:0] NUM_BLOCKS_RST  = 9'd256;
    localparam logic [BW-1:0] BLOCK_BYTES_RST = 17'd64;
    localparam logic [BW-1:0] BLOCK_BYTES_MIN = 17'd4;
    localparam logic [BW-1:0] BLOCK_BYTES_MAX = 17'd65536;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_FREE_ALL = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_dp_status;

endpackage

// ----- sv/fbpa_ctrl.sv -----
`timescale 1ns / 1ps

module fbpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fbpa_pkg::t_dp_status i_status,
    output fbpa_pkg::t_ctrl_cmd  o_cmd
);
    import fbpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_status.out_blocked) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    a_exec_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !i_status.out_blocked)
        else $error("update issued while result held");
    a_capture_then_exec_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC) && o_in_stall)
        else $error("capture did not enter update");
    a_no_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_cmd.capture)
        else $error("capture while busy");
`endif

endmodule

// ----- sv/fbpa_datapath.sv -----
`timescale 1ns / 1ps

module fbpa_datapath #(
    parameter int unsigned MAX_BLOCKS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [16:0]          i_cfg_data,
    input  logic [1:0]           i_in_opcode,
    input  logic [7:0]           i_in_block_index,
    input  fbpa_pkg::t_ctrl_cmd  i_cmd,
    output fbpa_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_out_status,
    output logic [7:0]           o_out_granted_index,
    output logic [23:0]          o_out_byte_offset,
    output logic [8:0]           o_out_free_count
);
    import fbpa_pkg::*;

    localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [CW-1:0] r_link [MAX_BLOCKS];
    logic [CW-1:0] r_rd_data;

    logic [CW-1:0] r_num_blocks;
    logic [BW-1:0] r_block_bytes;
    logic [CW-1:0] r_head;
    logic [CW-1:0] n_head;
    logic [CW-1:0] r_free;
    logic [CW-1:0] n_free;
    logic [CW-1:0] r_init;
    logic [CW-1:0] n_init;
    logic [1:0]    r_op;
    logic [7:0]    r_idx;

    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [7:0]    r_out_granted;
    logic [23:0]   r_out_offset;
    logic [CW-1:0] r_out_free;

    logic [CW-1:0] eff_n;
    logic [BW-1:0] eff_bytes;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic [CW-1:0] wr_data;
    logic [CW-1:0] link_val;
    logic [CW-1:0] free_dec;
    logic [1:0]    res_status;
    logic [7:0]    res_granted;
    logic [24:0]   product;

    always_comb begin
        if (r_num_blocks == '0) begin
            eff_n = CW'(1);
        end else if (32'(r_num_blocks) > 32'(MAX_BLOCKS)) begin
            eff_n = CW'(MAX_BLOCKS);
        end else begin
            eff_n = r_num_blocks;
        end
        if (r_block_bytes < BLOCK_BYTES_MIN) begin
            eff_bytes = BLOCK_BYTES_MIN;
        end else if (r_block_bytes > BLOCK_BYTES_MAX) begin
            eff_bytes = BLOCK_BYTES_MAX;
        end else begin
            eff_bytes = r_block_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_blocks  <= NUM_BLOCKS_RST;
            r_block_bytes <= BLOCK_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_BLOCKS:  r_num_blocks  <= i_cfg_data[CW-1:0];
                CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data;
            endcase
        end
    end

    // link store, read at capture, written at update
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_data <= r_link[AW'(r_head)];
        end
        if (wr_en) begin
            r_link[AW'(wr_addr)] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_opcode;
            r_idx <= i_in_block_index;
        end
    end

    assign free_dec = r_free - CW'(1);
    assign product  = 25'(res_granted) * 25'(eff_bytes);

    always_comb begin
        n_head      = r_head;
        n_free      = r_free;
        n_init      = r_init;
        wr_en       = 1'b0;
        wr_addr     = r_init;
        wr_data     = r_init + CW'(1);
        res_status  = ST_OK;
        res_granted = '0;
        link_val    = r_rd_data;
        unique case (t_opcode'(r_op))
            OP_ALLOC: begin
                if (r_init < eff_n) begin
                    wr_en  = i_cmd.exec;
                    n_init = r_init + CW'(1);
                end
                // lazy link of the head entry in this same transaction
                if ((r_init < eff_n) && (r_init == r_head)) begin
                    link_val = r_init + CW'(1);
                end else if (32'(r_head) >= 32'(MAX_BLOCKS)) begin
                    link_val = '0;
                end
                if (r_free != '0) begin
                    res_granted = r_head[7:0];
                    n_free      = free_dec;
                    if (free_dec != '0) begin
                        n_head = link_val;
                    end
                end else begin
                    res_status = ST_EMPTY;
                end
            end
            OP_FREE: begin
                if ((CW'(r_idx) < eff_n) && (r_free < eff_n)) begin
                    wr_en   = i_cmd.exec;
                    wr_addr = CW'(r_idx);
                    wr_data = (r_free != '0) ? r_head : eff_n;
                    n_head  = CW'(r_idx);
                    n_free  = r_free + CW'(1);
                end else begin
                    res_status = ST_REJECT;
                end
            end
            OP_FREE_ALL: begin
                n_free = eff_n;
                n_init = '0;
                n_head = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_free <= NUM_BLOCKS_RST;
            r_init <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_free <= n_free;
            r_init <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status  <= res_status;
            r_out_granted <= res_granted;
            r_out_offset  <= product[23:0];
            r_out_free    <= n_free;
        end
    end

    assign o_status.out_blocked = r_out_valid & i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_out_status         = r_out_status;
    assign o_out_granted_index  = r_out_granted;
    assign o_out_byte_offset    = r_out_offset;
    assign o_out_free_count     = r_out_free;

`ifndef SYNTHESIS
    a_exec_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("result lost after update");
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |->
            (r_out_granted == '0) && (r_out_offset == '0))
        else $error("grant fields set without a grant");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(MAX_BLOCKS))
        else $error("free count above pool size");
    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_free) && $stable(r_head) && $stable(r_init))
        else $error("pool state changed outside update");
`endif

endmodule

// ----- sv/fixed_block_pool_allocator_top.sv -----
`timescale 1ns / 1ps

// Fixed-size block pool allocator. Each transaction allocates a block, frees one
// block or frees the whole pool, and returns one result with status, granted index,
// byte offset and the free count after the request. When a request is accepted, the
// head's link entry is read from the synchronous link store; the update state that
// follows updates the pool and loads the result register, and no new request is
// accepted until that update is done. The input stalls during the update state, and
// the update is held off for as long as the previous result is still waiting on a
// stalled output. The free list is linked lazily, so no clearing pass follows reset
// or free-all; num_blocks and block_bytes are clamped to their legal ranges where
// used and should be written only while idle.
module fixed_block_pool_allocator_top #(
    parameter int unsigned MAX_BLOCKS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_in_opcode,
    input  logic [7:0]  i_in_block_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_status,
    output logic [7:0]  o_out_granted_index,
    output logic [23:0] o_out_byte_offset,
    output logic [8:0]  o_out_free_count
);
    import fbpa_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;

    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_opcode         (i_in_opcode),
        .i_in_block_index    (i_in_block_index),
        .i_cmd               (cmd),
        .o_status            (dp_status),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_status        (o_out_status),
        .o_out_granted_index (o_out_granted_index),
        .o_out_byte_offset   (o_out_byte_offset),
        .o_out_free_count    (o_out_free_count)
    );

endmodule
